// ===== rtl/sat_pkg.sv =====
`default_nettype none

package sat_pkg;

    // default sizes
    localparam int DEF_MAX_COLS  = 64;
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_SUM_WIDTH = 48;

    // field widths
    localparam int CFG_W   = 7;
    localparam int COORD_W = 6;
    localparam int CELL_W  = 32;
    localparam int OUT_W   = 48;

    // register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic             REG_GRID_COLS = 1'b0;
    localparam logic             REG_GRID_ROWS = 1'b1;
    localparam logic [CFG_W-1:0] GRID_RESET    = 7'd64;

    // command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic       accept_load;
        logic       accept_query;
        logic       ld_read;
        logic       ld_write;
        logic       q_read;
        logic [1:0] q_corner;
        logic       q_finish;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/summed_area_table_box_sum_core.sv =====
// channel   | handshake               | payload
// ----------+-------------------------+----------------------------------------------
// command   | start / busy            | command, restart, cell_value, x_first,
//           |                         | y_first, x_last, y_last
// result    | done (one-cycle strobe) | result_value, is_query, error
// config    | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// a load does one read of the entry to the left and one write, both on the single port
// of the integral store
// a query does four corner reads on that port, then one sum step
// the result beat comes on done in the cycle after the last step of the item
// reset clears the load position and the running sum; the store holds no valid data
// until a full load pass; the receiver cannot stall the result beat
`default_nettype none

module summed_area_table_box_sum_core #(
    parameter int MAX_COLS  = sat_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS  = sat_pkg::DEF_MAX_ROWS,
    parameter int SUM_WIDTH = sat_pkg::DEF_SUM_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [sat_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic        [sat_pkg::APB_DATA_W-1:0] pwdata,
    output logic             [sat_pkg::APB_DATA_W-1:0] prdata,
    output logic                                     pready,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                command,
    input  wire logic                                restart,
    input  wire logic signed [sat_pkg::CELL_W-1:0]   cell_value,
    input  wire logic        [sat_pkg::COORD_W-1:0]  x_first,
    input  wire logic        [sat_pkg::COORD_W-1:0]  y_first,
    input  wire logic        [sat_pkg::COORD_W-1:0]  x_last,
    input  wire logic        [sat_pkg::COORD_W-1:0]  y_last,
    output logic                                     done,
    output logic signed      [sat_pkg::OUT_W-1:0]    result_value,
    output logic                                     is_query,
    output logic                                     error
);

    import sat_pkg::*;

    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;
    logic             cfg_write;
    ctrl_cmd_t        cmd;

    // configuration registers
    sat_cfg #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cols      (cols),
        .rows      (rows),
        .cfg_write (cfg_write)
    );

    // sequencer
    sat_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .cmd     (cmd)
    );

    // store and arithmetic
    sat_dp #(
        .MAX_COLS  (MAX_COLS),
        .MAX_ROWS  (MAX_ROWS),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg_write),
        .cols         (cols),
        .rows         (rows),
        .restart      (restart),
        .cell_value   (cell_value),
        .x_first      (x_first),
        .y_first      (y_first),
        .x_last       (x_last),
        .y_last       (y_last),
        .done         (done),
        .result_value (result_value),
        .is_query     (is_query),
        .error        (error)
    );

endmodule

`default_nettype wire

// ===== rtl/sat_ram.sv =====
`default_nettype none

module sat_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [WIDTH-1:0]  wdata,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/sat_cfg.sv =====
`default_nettype none

module sat_cfg #(
    parameter int MAX_COLS = sat_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = sat_pkg::DEF_MAX_ROWS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sat_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [sat_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [sat_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic      [sat_pkg::CFG_W-1:0]       cols,
    output logic      [sat_pkg::CFG_W-1:0]       rows,
    output logic                                 cfg_write
);

    import sat_pkg::*;

    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    logic             reg_sel;

    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= GRID_RESET;
            rows_reg <= GRID_RESET;
        end
        else if (cfg_write)
        begin
            if (reg_sel == REG_GRID_COLS)
            begin
                cols_reg <= pwdata[CFG_W-1:0];
            end
            else
            begin
                rows_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    // read back
    assign prdata = (reg_sel == REG_GRID_COLS) ? APB_DATA_W'(cols_reg)
                                               : APB_DATA_W'(rows_reg);

    // effective grid size: zero counts as one, clamp to the maximum
    always_comb
    begin
        if (cols_reg == '0)
        begin
            cols = CFG_W'(1);
        end
        else if (32'(cols_reg) > MAX_COLS)
        begin
            cols = CFG_W'(MAX_COLS);
        end
        else
        begin
            cols = cols_reg;
        end

        if (rows_reg == '0)
        begin
            rows = CFG_W'(1);
        end
        else if (32'(rows_reg) > MAX_ROWS)
        begin
            rows = CFG_W'(MAX_ROWS);
        end
        else
        begin
            rows = rows_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sat_ctrl.sv =====
`default_nettype none

module sat_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               command,
    output logic                    busy,
    output sat_pkg::ctrl_cmd_t      cmd
);

    import sat_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LD_RD = 5'b00010,
        ST_LD_WR = 5'b00100,
        ST_Q_RD  = 5'b01000,
        ST_Q_SUM = 5'b10000
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       accept;

    assign accept = (state_reg == ST_IDLE) && start;
    assign busy   = (state_reg != ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cnt_next   = 2'd0;
                    state_next = (command == CMD_QUERY) ? ST_Q_RD : ST_LD_RD;
                end
            end
            ST_LD_RD:
            begin
                state_next = ST_LD_WR;
            end
            ST_LD_WR:
            begin
                state_next = ST_IDLE;
            end
            ST_Q_RD:
            begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = ST_Q_SUM;
                end
            end
            ST_Q_SUM:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // datapath commands
    always_comb
    begin
        cmd.accept_load  = accept && (command == CMD_LOAD);
        cmd.accept_query = accept && (command == CMD_QUERY);
        cmd.ld_read      = (state_reg == ST_LD_RD);
        cmd.ld_write     = (state_reg == ST_LD_WR);
        cmd.q_read       = (state_reg == ST_Q_RD);
        cmd.q_corner     = cnt_reg;
        cmd.q_finish     = (state_reg == ST_Q_SUM);
    end

    // the sum step follows the last of four corner reads
    a_sum_after_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_Q_SUM) |-> ($past(state_reg) == ST_Q_RD && $past(cnt_reg) == 2'd3))
        else $error("sum step without four corner reads");

    // an accepted beat makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

endmodule

`default_nettype wire

// ===== rtl/sat_dp.sv =====
`default_nettype none

module sat_dp #(
    parameter int MAX_COLS  = sat_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS  = sat_pkg::DEF_MAX_ROWS,
    parameter int SUM_WIDTH = sat_pkg::DEF_SUM_WIDTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire sat_pkg::ctrl_cmd_t                  cmd,
    input  wire logic                                cfg_write,
    input  wire logic        [sat_pkg::CFG_W-1:0]    cols,
    input  wire logic        [sat_pkg::CFG_W-1:0]    rows,
    input  wire logic                                restart,
    input  wire logic signed [sat_pkg::CELL_W-1:0]   cell_value,
    input  wire logic        [sat_pkg::COORD_W-1:0]  x_first,
    input  wire logic        [sat_pkg::COORD_W-1:0]  y_first,
    input  wire logic        [sat_pkg::COORD_W-1:0]  x_last,
    input  wire logic        [sat_pkg::COORD_W-1:0]  y_last,
    output logic                                     done,
    output logic signed      [sat_pkg::OUT_W-1:0]    result_value,
    output logic                                     is_query,
    output logic                                     error
);

    import sat_pkg::*;

    localparam int DEPTH  = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // load position and running column sum
    logic [CFG_W-1:0]     ld_col_reg;
    logic [CFG_W-1:0]     ld_row_reg;
    logic [SUM_WIDTH-1:0] run_sum_reg;
    logic                 loaded_reg;

    // query rectangle
    logic [COORD_W-1:0]   xf_reg;
    logic [COORD_W-1:0]   yf_reg;
    logic [COORD_W-1:0]   xl_reg;
    logic [COORD_W-1:0]   yl_reg;
    logic                 qerr_reg;

    // corner read pipeline
    logic                 pend_reg;
    logic [1:0]           pend_idx_reg;
    logic [SUM_WIDTH-1:0] acc_reg;

    // result beat
    logic                    done_reg;
    logic signed [OUT_W-1:0] result_reg;
    logic                    is_query_reg;
    logic                    error_reg;

    logic                 clr;
    logic [CFG_W-1:0]     col_eff;
    logic [CFG_W-1:0]     row_eff;
    logic [SUM_WIDTH-1:0] sum_base;
    logic [SUM_WIDTH-1:0] cell_ext;
    logic [SUM_WIDTH-1:0] sum_new;
    logic [SUM_WIDTH-1:0] left;
    logic [SUM_WIDTH-1:0] integ;
    logic [CFG_W-1:0]     row_inc;
    logic [CFG_W-1:0]     col_inc;
    logic                 q_err;
    logic [CFG_W-1:0]     qx;
    logic [CFG_W-1:0]     qy;
    logic                 corner_zero;
    logic [SUM_WIDTH-1:0] corner_data;
    logic [SUM_WIDTH-1:0] acc_base;
    logic [SUM_WIDTH-1:0] acc_sum;
    logic [ADDR_W-1:0]    ram_addr;
    logic [SUM_WIDTH-1:0] ram_rdata;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [CFG_W-1:0] c,
                                                  input logic [CFG_W-1:0] r);
        logic [31:0] lin;
        lin = 32'(c) * 32'(MAX_ROWS) + 32'(r);
        return lin[ADDR_W-1:0];
    endfunction

    // start of a load: restart, wrap after a full grid or out of range
    assign clr      = restart || loaded_reg || (ld_col_reg >= cols) || (ld_row_reg >= rows);
    assign col_eff  = clr ? '0 : ld_col_reg;
    assign row_eff  = clr ? '0 : ld_row_reg;
    assign sum_base = (clr || (row_eff == '0)) ? '0 : run_sum_reg;
    assign cell_ext = SUM_WIDTH'(cell_value);
    assign sum_new  = sum_base + cell_ext;

    // integral entry: running sum plus the entry to the left
    assign left    = (ld_col_reg != '0) ? ram_rdata : '0;
    assign integ   = run_sum_reg + left;
    assign row_inc = ld_row_reg + CFG_W'(1);
    assign col_inc = ld_col_reg + CFG_W'(1);

    // query check
    assign q_err = !loaded_reg || (x_first > x_last) || (y_first > y_last)
                   || ({1'b0, x_last} >= cols) || ({1'b0, y_last} >= rows);

    // corner coordinates: bit 0 picks the column left of the box, bit 1 the row above
    assign qx = cmd.q_corner[0] ? (CFG_W'(xf_reg) - CFG_W'(1)) : CFG_W'(xl_reg);
    assign qy = cmd.q_corner[1] ? (CFG_W'(yf_reg) - CFG_W'(1)) : CFG_W'(yl_reg);

    // memory address
    always_comb
    begin
        if (cmd.ld_read)
        begin
            ram_addr = addr_of(ld_col_reg - CFG_W'(1), ld_row_reg);
        end
        else if (cmd.ld_write)
        begin
            ram_addr = addr_of(ld_col_reg, ld_row_reg);
        end
        else
        begin
            ram_addr = addr_of(qx, qy);
        end
    end

    sat_ram #(
        .WIDTH  (SUM_WIDTH),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (cmd.ld_write),
        .addr  (ram_addr),
        .wdata (integ),
        .rdata (ram_rdata)
    );

    // corner accumulation: corners off the grid edge count as zero
    assign corner_zero = (pend_idx_reg[0] && (xf_reg == '0))
                         || (pend_idx_reg[1] && (yf_reg == '0));
    assign corner_data = corner_zero ? '0 : ram_rdata;
    assign acc_base    = (pend_idx_reg == 2'd0) ? '0 : acc_reg;
    assign acc_sum     = (pend_idx_reg[0] ^ pend_idx_reg[1]) ? (acc_base - corner_data)
                                                             : (acc_base + corner_data);

    // load position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_col_reg  <= '0;
            ld_row_reg  <= '0;
            run_sum_reg <= '0;
            loaded_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            ld_col_reg  <= '0;
            ld_row_reg  <= '0;
            run_sum_reg <= '0;
            loaded_reg  <= 1'b0;
        end
        else if (cmd.accept_load)
        begin
            ld_col_reg  <= col_eff;
            ld_row_reg  <= row_eff;
            run_sum_reg <= sum_new;
            loaded_reg  <= 1'b0;
        end
        else if (cmd.ld_write)
        begin
            if (row_inc >= rows)
            begin
                ld_row_reg <= '0;
                if (col_inc >= cols)
                begin
                    ld_col_reg <= '0;
                    loaded_reg <= 1'b1;
                end
                else
                begin
                    ld_col_reg <= col_inc;
                end
            end
            else
            begin
                ld_row_reg <= row_inc;
            end
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= cmd.q_read;
            done_reg <= cmd.ld_write || cmd.q_finish;
        end
    end

    // query operands and accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.accept_query)
        begin
            xf_reg   <= x_first;
            yf_reg   <= y_first;
            xl_reg   <= x_last;
            yl_reg   <= y_last;
            qerr_reg <= q_err;
        end
        pend_idx_reg <= cmd.q_corner;
        if (pend_reg)
        begin
            acc_reg <= acc_sum;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        if (cmd.ld_write)
        begin
            result_reg   <= OUT_W'($signed(integ));
            is_query_reg <= 1'b0;
            error_reg    <= 1'b0;
        end
        else if (cmd.q_finish)
        begin
            result_reg   <= qerr_reg ? '0 : OUT_W'($signed(acc_sum));
            is_query_reg <= 1'b1;
            error_reg    <= qerr_reg;
        end
    end

    assign done         = done_reg;
    assign result_value = result_reg;
    assign is_query     = is_query_reg;
    assign error        = error_reg;

    // every beat stands for one cycle and the next cannot follow at once
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result beat longer than one cycle");

    // load beats never flag an error
    a_load_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !is_query_reg) |-> !error_reg)
        else $error("load beat with error");

    // the sum step sees the data of the last corner
    a_finish_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.q_finish |-> (pend_reg && pend_idx_reg == 2'd3))
        else $error("query finished without last corner data");

endmodule

`default_nettype wire
